>>> sv/periodic_task_dispatcher_core_assert.svh
// Assertion macros for the periodic task dispatcher checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define PTD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptd check failed");

// Next-cycle implication, masked during reset.
`define PTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptd check failed");

// Next-cycle implication that also covers reset itself.
`define PTD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ptd check failed");

`endif

>>> sv/ptd_pkg.sv
// Shared types and constants of the periodic task dispatcher.
// No dependencies; used by every other file of the block except the assertion macro header.
package ptd_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int SLOT_W_DEF    = 3;
  localparam int HID_W         = 8;
  localparam int PER_W         = 32;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_CREATE     = 2'd1,
    KIND_SET_PERIOD = 2'd2,
    KIND_SET_ENABLE = 2'd3
  } kind_t;

  // Write enables of the task table, one per field array
  typedef struct packed {
    logic hid_we;
    logic per_we;
    logic en_we;
  } tbl_we_t;

  // Status of the shared remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_sts_t;

endpackage

>>> sv/ptd_in_if.sv
// Input item channel of the periodic task dispatcher.
// Depends on ptd_pkg.
interface ptd_in_if;
  logic                      valid;
  logic                      ready;
  ptd_pkg::kind_t            kind;
  logic [ptd_pkg::HID_W-1:0] handler_id;
  logic [ptd_pkg::PER_W-1:0] period;
  logic                      enable;

  modport source (output valid, kind, handler_id, period, enable, input ready);
  modport sink   (input valid, kind, handler_id, period, enable, output ready);
endinterface

>>> sv/ptd_out_if.sv
// Result item channel of the periodic task dispatcher.
// Depends on ptd_pkg.
interface ptd_out_if #(
  parameter int SLOT_W = ptd_pkg::SLOT_W_DEF
);
  logic                      valid;
  logic                      ready;
  logic [ptd_pkg::HID_W-1:0] due_handler;
  logic [SLOT_W-1:0]         due_slot;
  logic                      last;

  modport source (output valid, due_handler, due_slot, last, input ready);
  modport sink   (input valid, due_handler, due_slot, last, output ready);
endinterface

>>> sv/ptd_table.sv
// Task table memory: handler, period and enable arrays, one write and one
// registered read port each. Depends on ptd_pkg.
module ptd_table #(
  parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF,
  parameter int SLOT_W    = ptd_pkg::SLOT_W_DEF
) (
  input  logic                      clk,
  input  ptd_pkg::tbl_we_t          we,
  input  logic [SLOT_W-1:0]         wr_addr,
  input  logic [ptd_pkg::HID_W-1:0] wr_hid,
  input  logic [ptd_pkg::PER_W-1:0] wr_per,
  input  logic                      wr_en,
  input  logic [SLOT_W-1:0]         rd_addr,
  output logic [ptd_pkg::HID_W-1:0] rd_hid,
  output logic [ptd_pkg::PER_W-1:0] rd_per,
  output logic                      rd_en
);

  logic [ptd_pkg::HID_W-1:0] hid_mem [MAX_TASKS];
  logic [ptd_pkg::PER_W-1:0] per_mem [MAX_TASKS];
  logic                      en_mem  [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we.hid_we) hid_mem[wr_addr] <= wr_hid;
    if (we.per_we) per_mem[wr_addr] <= wr_per;
    if (we.en_we)  en_mem[wr_addr]  <= wr_en;
  end

  always_ff @(posedge clk) begin
    rd_hid <= hid_mem[rd_addr];
    rd_per <= per_mem[rd_addr];
    rd_en  <= en_mem[rd_addr];
  end

endmodule

>>> sv/ptd_rem_unit.sv
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Depends on ptd_pkg.
module ptd_rem_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ptd_pkg::PER_W-1:0] dividend,
  input  logic [ptd_pkg::PER_W-1:0] divisor,
  output ptd_pkg::div_sts_t         sts
);

  logic [ptd_pkg::PER_W-1:0]     rem_r;
  logic [ptd_pkg::PER_W-1:0]     dvd_r;
  logic [ptd_pkg::PER_W-1:0]     dsr_r;
  logic [ptd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [ptd_pkg::PER_W:0]       shl;
  logic [ptd_pkg::PER_W:0]       diff;
  logic [ptd_pkg::PER_W-1:0]     rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    shl  = {rem_r, dvd_r[ptd_pkg::PER_W-1]};
    diff = shl - {1'b0, dsr_r};
    if (!diff[ptd_pkg::PER_W]) rem_nxt = diff[ptd_pkg::PER_W-1:0];
    else                       rem_nxt = shl[ptd_pkg::PER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= ptd_pkg::DIV_CNT_W'(ptd_pkg::DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - ptd_pkg::DIV_CNT_W'(1);
      if (cnt_r == ptd_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[ptd_pkg::PER_W-2:0], 1'b0};
    end
  end

  assign sts.done     = done_r;
  assign sts.rem_zero = (rem_r == '0);

endmodule

>>> sv/periodic_task_dispatcher_core.sv
// Periodic task dispatcher top level: sequencer, task count, tick counter
// and result register. Depends on ptd_pkg, ptd_in_if, ptd_out_if,
// ptd_table and ptd_rem_unit.
//
// The block keeps a table of up to MAX_TASKS tasks (handler id, period,
// enable) and a 32-bit tick counter. A create item is written as it is
// accepted and the block is ready again at once; a create into a full
// table is dropped. Set-period and set-enable items walk the table, a read
// state and a check state per occupied slot, rewriting every slot whose
// handler id matches. A tick item walks the occupied slots in order; each
// enabled slot with a nonzero period goes through the shared remainder
// unit (one bit per cycle, 32 steps) to test whether the period divides
// the tick counter. A stalled result channel can hold the tick walk.
// Due tasks leave as result items in slot order; one is held back until
// the next is found or the walk ends, so the final item of a tick carries
// last. Input ready is low while a walk is in progress. Results sit in an
// output register, so the next item may be accepted while the final
// result of a tick still waits to be taken. No clearing pass is needed
// after reset: only slots below the task count are ever read.
module periodic_task_dispatcher_core #(
  parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptd_in_if.sink      in_ch,
  ptd_out_if.source   out_ch
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CHECK = 6'b000100,
    S_DIV   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  // control state
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ptd_pkg::PER_W-1:0] tick_r, tick_nxt;
  logic                      pend_valid_r, pend_valid_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // payload registers
  ptd_pkg::kind_t            op_kind_r, op_kind_nxt;
  logic [ptd_pkg::HID_W-1:0] op_hid_r, op_hid_nxt;
  logic [ptd_pkg::PER_W-1:0] op_per_r, op_per_nxt;
  logic                      op_en_r, op_en_nxt;
  logic [ptd_pkg::HID_W-1:0] pend_hid_r, pend_hid_nxt;
  logic [SLOT_W-1:0]         pend_slot_r, pend_slot_nxt;
  logic [ptd_pkg::HID_W-1:0] out_hid_r, out_hid_nxt;
  logic [SLOT_W-1:0]         out_slot_r, out_slot_nxt;
  logic                      out_last_r, out_last_nxt;

  // table and remainder unit wiring
  ptd_pkg::tbl_we_t          tbl_we;
  logic [SLOT_W-1:0]         wr_addr;
  logic [ptd_pkg::HID_W-1:0] wr_hid;
  logic [ptd_pkg::PER_W-1:0] wr_per;
  logic                      wr_en;
  logic [SLOT_W-1:0]         cur_slot;
  logic [ptd_pkg::HID_W-1:0] rd_hid;
  logic [ptd_pkg::PER_W-1:0] rd_per;
  logic                      rd_en;
  logic                      div_start;
  ptd_pkg::div_sts_t         div_sts;

  logic in_fire;
  logic out_free;

  assign cur_slot = idx_r[SLOT_W-1:0];
  assign in_fire  = in_ch.valid && in_ch.ready;
  // the result register can take a new item this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  ptd_table #(
    .MAX_TASKS (MAX_TASKS),
    .SLOT_W    (SLOT_W)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .wr_addr (wr_addr),
    .wr_hid  (wr_hid),
    .wr_per  (wr_per),
    .wr_en   (wr_en),
    .rd_addr (cur_slot),
    .rd_hid  (rd_hid),
    .rd_per  (rd_per),
    .rd_en   (rd_en)
  );

  ptd_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tick_r),
    .divisor  (rd_per),
    .sts      (div_sts)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    tick_nxt       = tick_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    op_kind_nxt    = op_kind_r;
    op_hid_nxt     = op_hid_r;
    op_per_nxt     = op_per_r;
    op_en_nxt      = op_en_r;
    pend_hid_nxt   = pend_hid_r;
    pend_slot_nxt  = pend_slot_r;
    out_hid_nxt    = out_hid_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    tbl_we         = '0;
    wr_addr        = cur_slot;
    wr_hid         = op_hid_r;
    wr_per         = op_per_r;
    wr_en          = op_en_r;
    div_start      = 1'b0;

    // drop the held result once taken
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_kind_nxt = in_ch.kind;
          op_hid_nxt  = in_ch.handler_id;
          op_per_nxt  = in_ch.period;
          op_en_nxt   = in_ch.enable;
          idx_nxt     = '0;
          if (in_ch.kind == ptd_pkg::KIND_CREATE) begin
            // append in place; a full table drops the item
            if (cnt_r < CNT_W'(MAX_TASKS)) begin
              tbl_we  = '{hid_we: 1'b1, per_we: 1'b1, en_we: 1'b1};
              wr_addr = cnt_r[SLOT_W-1:0];
              wr_hid  = in_ch.handler_id;
              wr_per  = in_ch.period;
              wr_en   = in_ch.enable;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // the slot address settles here, data is there next cycle
        if (idx_r == cnt_r) begin
          state_nxt = (op_kind_r == ptd_pkg::KIND_TICK) ? S_FLUSH : S_IDLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_kind_r == ptd_pkg::KIND_TICK) begin
          if (rd_en && (rd_per != '0)) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end else begin
          if (rd_hid == op_hid_r) begin
            if (op_kind_r == ptd_pkg::KIND_SET_PERIOD) tbl_we.per_we = 1'b1;
            else                                       tbl_we.en_we  = 1'b1;
          end
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_EMIT: begin
        // a further due task exists, so the held one is not the last
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_hid_nxt   = pend_hid_r;
            out_slot_nxt  = pend_slot_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_hid_nxt   = rd_hid;
          pend_slot_nxt  = cur_slot;
          idx_nxt        = idx_r + CNT_W'(1);
          state_nxt      = S_READ;
        end
      end
      S_FLUSH: begin
        // release the held task marked last, then advance the counter
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_hid_nxt   = pend_hid_r;
            out_slot_nxt  = pend_slot_r;
            out_last_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          tick_nxt       = tick_r + ptd_pkg::PER_W'(1);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      cnt_r        <= '0;
      tick_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      tick_r       <= tick_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_kind_r   <= op_kind_nxt;
    op_hid_r    <= op_hid_nxt;
    op_per_r    <= op_per_nxt;
    op_en_r     <= op_en_nxt;
    pend_hid_r  <= pend_hid_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_hid_r   <= out_hid_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.due_handler = out_hid_r;
  assign out_ch.due_slot    = out_slot_r;
  assign out_ch.last        = out_last_r;

endmodule

>>> sv/ptd_checker.sv
// Port-level checks of the periodic task dispatcher, bound to the top level.
// Depends on ptd_pkg and periodic_task_dispatcher_core_assert.svh.
`include "periodic_task_dispatcher_core_assert.svh"

module ptd_checker #(
  parameter int SLOT_W = ptd_pkg::SLOT_W_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ptd_pkg::HID_W-1:0] out_due_handler,
  input logic [SLOT_W-1:0]         out_due_slot,
  input logic                      out_last
);

  logic tick_fire;
  logic update_fire;
  logic out_stall;

  assign tick_fire   = in_valid && in_ready && (in_kind == ptd_pkg::KIND_TICK);
  assign update_fire = in_valid && in_ready &&
                       ((in_kind == ptd_pkg::KIND_SET_PERIOD) ||
                        (in_kind == ptd_pkg::KIND_SET_ENABLE));
  assign out_stall   = out_valid && !out_ready;

  // hold a stalled result
  `PTD_ASSERT_NEXT(a_out_hold, out_stall, out_valid)
  `PTD_ASSERT_NEXT(a_out_stable, out_stall,
                   $stable(out_due_handler) && $stable(out_due_slot) && $stable(out_last))
  // a walk keeps the input closed on the following cycle
  `PTD_ASSERT_NEXT(a_walk_busy, tick_fire || update_fire, !in_ready)
  // reset leaves the block open for input with no result pending
  `PTD_ASSERT_NEXT_ALWAYS(a_reset_state, !rst_n, in_ready && !out_valid)

endmodule

bind periodic_task_dispatcher_core ptd_checker #(
  .SLOT_W (SLOT_W)
) u_ptd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_due_handler (out_ch.due_handler),
  .out_due_slot    (out_ch.due_slot),
  .out_last        (out_ch.last)
);
